### rtl/pgp_pkg.sv
package pgp_pkg;

  localparam int PALETTE_DEPTH = 8;
  localparam int GLYPH_WIDTH   = 8;
  localparam int GLYPH_HEIGHT  = 16;
  localparam int KERN_PAIRS    = 23;
  localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    CFG_PROPORTIONAL   = 3'd0,
    CFG_SPACE_NARROW   = 3'd1,
    CFG_X_SCALE        = 3'd2,
    CFG_Y_SCALE        = 3'd3,
    CFG_PALETTE_ENABLE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  char_code;
    logic        first_char;
    logic        last_char;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] text_color;
    logic        fill_enable;
    logic [15:0] fill_color;
    logic [2:0]  palette_slot;
    logic [15:0] palette_color;
  } item_t;

  typedef struct packed {
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [15:0] cur_color;
    logic [15:0] base_color;
    logic        fill_on;
    logic [15:0] back_color;
    logic [7:0]  prev_byte;
    logic        esc_pending;
  } ctx_t;

  typedef struct packed {
    logic       proportional;
    logic       space_narrow;
    logic [2:0] x_scale;
    logic [2:0] y_scale;
    logic       palette_enable;
  } cfg_t;

  typedef struct packed {
    logic        glyph_valid;
    logic [7:0]  glyph;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic [15:0] glyph_color;
    logic        fill_valid;
    logic [15:0] fill_x;
    logic [5:0]  fill_width;
    logic [6:0]  fill_height;
    logic [15:0] next_x;
    logic        end_of_string;
  } res_t;

  typedef struct packed {
    logic signed [3:0] lft;
    logic signed [3:0] rgt;
  } hshift_t;

  typedef logic [15:0] kern_pair_t;

  localparam kern_pair_t KERN_TAB [KERN_PAIRS] = '{
    {"v","i"}, {"i","t"}, {"i","f"}, {"l","t"}, {"l","f"}, {"l","v"}, {"l","T"},
    {"r","i"}, {"r","l"}, {"L","T"}, {"T","a"}, {"T","e"}, {"T","i"}, {"T","o"},
    {"T","u"}, {"T","y"}, {"T","r"}, {"T","w"}, {"F","i"}, {"F","l"}, {"F","A"},
    {"6","7"}, {"1","7"}
  };

  // per-character left and right shifts, unscaled
  function automatic hshift_t hshift_of(input logic [7:0] c);
    hshift_t h;
    h = '{lft: 4'sd0, rgt: 4'sd0};
    unique case (c)
      " ":                     h = '{lft:  4'sd0, rgt: -4'sd5};
      ".", ",", ":", ";":      h = '{lft: -4'sd2, rgt: -4'sd2};
      "'":                     h = '{lft: -4'sd3, rgt: -4'sd1};
      "!":                     h = '{lft: -4'sd3, rgt: -4'sd2};
      "$", "%", "&", "*",
      "T", "V", "Y":           h = '{lft:  4'sd0, rgt:  4'sd1};
      "f", "t":                h = '{lft: -4'sd1, rgt: -4'sd1};
      "i", "l":                h = '{lft: -4'sd2, rgt:  4'sd0};
      "m", "w":                h = '{lft: -4'sd1, rgt:  4'sd1};
      "1", "a", "b", "c", "d", "e", "g", "h", "j", "k", "n", "o", "p", "q",
      "r", "s", "u", "v", "x", "y", "z", "I", "J", "_", 8'hBA:
                               h = '{lft: -4'sd1, rgt:  4'sd0};
      default:                 h = '{lft:  4'sd0, rgt:  4'sd0};
    endcase
    return h;
  endfunction

  // downward shift of control glyphs, unscaled
  function automatic logic [1:0] vshift_of(input logic [7:0] c);
    logic [1:0] v;
    unique case (c)
      8'h0E:                      v = 2'd1;
      8'h10, 8'h11, 8'h1E, 8'h1F: v = 2'd2;
      8'h1A, 8'h1B:               v = 2'd3;
      default:                    v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic kern_hit(input logic [7:0] a, input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KERN_PAIRS; i++) begin
      if (KERN_TAB[i] == {a, b}) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

### rtl/pgp_place.sv
module pgp_place (
  input  pgp_pkg::item_t             item,
  input  pgp_pkg::ctx_t              ctx,
  input  pgp_pkg::cfg_t              cfg,
  input  logic [15:0]                pal_rd_data,
  output logic [pgp_pkg::PAL_AW-1:0] pal_rd_idx,
  output pgp_pkg::ctx_t              ctx_nxt,
  output pgp_pkg::res_t              res,
  output logic                       res_valid
);

  pgp_pkg::ctx_t    eff;
  pgp_pkg::hshift_t hs;
  logic [7:0]       c;
  logic signed [7:0] l8, r8, ls, rs, gw, fw_sum;
  logic [4:0]       vprod;
  logic             kern;
  logic [15:0]      x, nx, cy;
  logic             pal_sel;

  assign c          = item.char_code;
  assign pal_rd_idx = pgp_pkg::PAL_AW'(c - pgp_pkg::CH_ONE);
  assign pal_sel    = (c >= pgp_pkg::CH_ONE) &&
                      ((c - pgp_pkg::CH_ONE) < 8'(pgp_pkg::PALETTE_DEPTH));

  always_comb begin
    // string start loads the context
    eff = ctx;
    if (item.first_char) begin
      eff.pen_x       = item.start_x;
      eff.pen_y       = item.start_y;
      eff.base_color  = item.text_color;
      eff.cur_color   = item.text_color;
      eff.fill_on     = item.fill_enable;
      eff.back_color  = item.fill_color;
      eff.esc_pending = 1'b0;
    end

    hs = pgp_pkg::hshift_of(c);
    if (c == pgp_pkg::CH_SPACE) begin
      hs.rgt = cfg.space_narrow ? -4'sd5 : 4'sd0;
    end
    l8 = cfg.proportional ? 8'(hs.lft) : 8'sd0;
    r8 = cfg.proportional ? 8'(hs.rgt) : 8'sd0;
    ls = 8'(l8 * $signed({5'b0, cfg.x_scale}));
    rs = 8'(r8 * $signed({5'b0, cfg.x_scale}));
    gw = 8'(pgp_pkg::GLYPH_WIDTH * cfg.x_scale);
    fw_sum = 8'(gw + ls + rs);
    kern = !item.first_char && cfg.proportional && pgp_pkg::kern_hit(ctx.prev_byte, c);
    x  = 16'(eff.pen_x + {{8{ls[7]}}, ls} - (kern ? {13'b0, cfg.x_scale} : 16'd0));
    nx = 16'(x + {{8{gw[7]}}, gw} + {{8{rs[7]}}, rs});
    vprod = 5'(pgp_pkg::vshift_of(c) * cfg.y_scale);
    cy = 16'(eff.pen_y + {12'b0, vprod[4:1]});

    ctx_nxt   = ctx;
    res       = '0;
    res_valid = 1'b0;

    if (item.req_type) begin
      // palette write: context untouched
      ctx_nxt = ctx;
    end else if (eff.esc_pending) begin
      ctx_nxt = eff;
      ctx_nxt.esc_pending = 1'b0;
      ctx_nxt.prev_byte   = c;
      if (cfg.palette_enable) begin
        if (c == pgp_pkg::CH_ZERO) begin
          ctx_nxt.cur_color = eff.base_color;
        end else if (pal_sel) begin
          ctx_nxt.cur_color = pal_rd_data;
        end
      end
      if (item.last_char) begin
        // end marker after a trailing escape
        res_valid         = 1'b1;
        res.next_x        = eff.pen_x;
        res.end_of_string = 1'b1;
      end
    end else if (c == pgp_pkg::CH_BS && !item.last_char) begin
      ctx_nxt = eff;
      ctx_nxt.esc_pending = 1'b1;
      ctx_nxt.prev_byte   = c;
    end else begin
      ctx_nxt = eff;
      ctx_nxt.pen_x     = nx;
      ctx_nxt.prev_byte = c;
      res_valid         = 1'b1;
      res.glyph_valid   = 1'b1;
      res.glyph         = c;
      res.cursor_x      = x;
      res.cursor_y      = cy;
      res.glyph_color   = eff.cur_color;
      res.fill_valid    = eff.fill_on;
      if (eff.fill_on) begin
        res.fill_x      = eff.pen_x;
        res.fill_width  = fw_sum[5:0];
        res.fill_height = 7'(pgp_pkg::GLYPH_HEIGHT * cfg.y_scale);
      end
      res.next_x        = nx;
      res.end_of_string = item.last_char;
    end
  end

endmodule

### rtl/proportional_glyph_placement.sv
// Proportional glyph placement. Takes one string byte (or one palette write)
// per beat and returns at most one result beat: a placed glyph with cursor,
// optional background rectangle and the advanced pen, or an end marker when a
// string finishes on a colour escape. A byte enters the input register, the
// placement is worked out in one pass of logic against the string context and
// lands in the output register when the input stage advances, so a byte can be
// taken every cycle while the output register drains; the loop through the pen
// position and colour context closes in that pass. The input stage keeps taking
// beats while the output register still holds a result, stalling only when
// both are full. Configuration writes are always ready and are meant to land
// while no string byte is in flight. Palette entries read before being
// written return an undefined colour.
module proportional_glyph_placement (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_char_code,
  input  logic        in_first_char,
  input  logic        in_last_char,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic [15:0] in_text_color,
  input  logic        in_fill_enable,
  input  logic [15:0] in_fill_color,
  input  logic [2:0]  in_palette_slot,
  input  logic [15:0] in_palette_color,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_glyph_valid,
  output logic [7:0]  out_glyph,
  output logic signed [15:0] out_cursor_x,
  output logic signed [15:0] out_cursor_y,
  output logic [15:0] out_glyph_color,
  output logic        out_fill_valid,
  output logic signed [15:0] out_fill_x,
  output logic [5:0]  out_fill_width,
  output logic [6:0]  out_fill_height,
  output logic signed [15:0] out_next_x,
  output logic        out_end_of_string
);

  pgp_pkg::cfg_t  cfg_r;
  pgp_pkg::ctx_t  ctx_r, ctx_nxt;
  pgp_pkg::item_t item_r;
  pgp_pkg::res_t  res, res_r;
  logic           s1_v_r;
  logic           out_valid_r;
  logic           res_valid;
  logic           s1_adv;
  logic           in_fire;
  logic [15:0]    pal_r [pgp_pkg::PALETTE_DEPTH];
  logic [pgp_pkg::PAL_AW-1:0] pal_rd_idx;
  logic [15:0]    pal_rd_data;

  // config registers: the user must write them only between strings; the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{proportional: 1'b1, space_narrow: 1'b1, x_scale: 3'd1,
                 y_scale: 3'd1, palette_enable: 1'b0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pgp_pkg::CFG_PROPORTIONAL:   cfg_r.proportional   <= cfg_data[0];
        pgp_pkg::CFG_SPACE_NARROW:   cfg_r.space_narrow   <= cfg_data[0];
        pgp_pkg::CFG_X_SCALE:        cfg_r.x_scale        <= cfg_data[2:0];
        pgp_pkg::CFG_Y_SCALE:        cfg_r.y_scale        <= cfg_data[2:0];
        pgp_pkg::CFG_PALETTE_ENABLE: cfg_r.palette_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the input stage moves on when the output register is free or being drained
  assign s1_adv   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= '{req_type: in_req_type, char_code: in_char_code,
                  first_char: in_first_char, last_char: in_last_char,
                  start_x: in_start_x, start_y: in_start_y,
                  text_color: in_text_color, fill_enable: in_fill_enable,
                  fill_color: in_fill_color, palette_slot: in_palette_slot,
                  palette_color: in_palette_color};
    end
  end

  // palette, no reset: unwritten entries read as whatever they hold
  assign pal_rd_data = pal_r[pal_rd_idx];

  always_ff @(posedge clk) begin
    if (s1_adv && item_r.req_type &&
        ({1'b0, item_r.palette_slot} < 4'(pgp_pkg::PALETTE_DEPTH))) begin
      pal_r[pgp_pkg::PAL_AW'(item_r.palette_slot)] <= item_r.palette_color;
    end
  end

  pgp_place u_place (
    .item        (item_r),
    .ctx         (ctx_r),
    .cfg         (cfg_r),
    .pal_rd_data (pal_rd_data),
    .pal_rd_idx  (pal_rd_idx),
    .ctx_nxt     (ctx_nxt),
    .res         (res),
    .res_valid   (res_valid)
  );

  // string context follows each processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else if (s1_adv) begin
      ctx_r <= ctx_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_glyph_valid   = res_r.glyph_valid;
  assign out_glyph         = res_r.glyph;
  assign out_cursor_x      = res_r.cursor_x;
  assign out_cursor_y      = res_r.cursor_y;
  assign out_glyph_color   = res_r.glyph_color;
  assign out_fill_valid    = res_r.fill_valid;
  assign out_fill_x        = res_r.fill_x;
  assign out_fill_width    = res_r.fill_width;
  assign out_fill_height   = res_r.fill_height;
  assign out_next_x        = res_r.next_x;
  assign out_end_of_string = res_r.end_of_string;

  // an empty input stage always takes a beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ready)
    else $error("input stage empty but not ready");

  // a string's last byte never leaves an escape pending
  a_no_esc_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !item_r.req_type && item_r.last_char) |=> !ctx_r.esc_pending)
    else $error("escape left pending after last byte");

  // palette writes give no result
  a_pal_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && item_r.req_type) |-> !res_valid)
    else $error("palette write produced a result");

  // a fresh result only comes from a processed beat
  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result appeared without a processed beat");

  // end markers only close a string
  a_marker_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.glyph_valid) |-> res_r.end_of_string)
    else $error("end marker without end of string");

endmodule

### verif/proportional_glyph_placement_tb.sv
`timescale 1ns / 1ps

module proportional_glyph_placement_tb;

  // request kinds carried by in_req_type
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_PALETTE = 1'b1;

  // two register stages, plus margin before the block counts as idle
  localparam int LATENCY        = 2;
  localparam int SETTLE_CYCLES  = LATENCY + 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {IDLE_RANDOM, IDLE_NONE, IDLE_LIGHT} idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [7:0]  in_char_code;
  logic        in_first_char;
  logic        in_last_char;
  logic [15:0] in_start_x;
  logic [15:0] in_start_y;
  logic [15:0] in_text_color;
  logic        in_fill_enable;
  logic [15:0] in_fill_color;
  logic [2:0]  in_palette_slot;
  logic [15:0] in_palette_color;
  logic        out_valid;
  logic        out_ready;
  logic        out_glyph_valid;
  logic [7:0]  out_glyph;
  logic [15:0] out_cursor_x;
  logic [15:0] out_cursor_y;
  logic [15:0] out_glyph_color;
  logic        out_fill_valid;
  logic [15:0] out_fill_x;
  logic [5:0]  out_fill_width;
  logic [6:0]  out_fill_height;
  logic [15:0] out_next_x;
  logic        out_end_of_string;

  proportional_glyph_placement uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_char_code      (in_char_code),
    .in_first_char     (in_first_char),
    .in_last_char      (in_last_char),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_text_color     (in_text_color),
    .in_fill_enable    (in_fill_enable),
    .in_fill_color     (in_fill_color),
    .in_palette_slot   (in_palette_slot),
    .in_palette_color  (in_palette_color),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_glyph_valid   (out_glyph_valid),
    .out_glyph         (out_glyph),
    .out_cursor_x      (out_cursor_x),
    .out_cursor_y      (out_cursor_y),
    .out_glyph_color   (out_glyph_color),
    .out_fill_valid    (out_fill_valid),
    .out_fill_x        (out_fill_x),
    .out_fill_width    (out_fill_width),
    .out_fill_height   (out_fill_height),
    .out_next_x        (out_next_x),
    .out_end_of_string (out_end_of_string)
  );

  // ---------------------------------------------------------------------------
  // placement model state: string context, palette and register copies
  // ---------------------------------------------------------------------------
  logic [15:0] pen_x, pen_y, cur_color, base_color, back_color;
  logic        fill_on, esc_pending;
  logic [7:0]  prev_byte;
  logic [15:0] palette_mem [pgp_pkg::PALETTE_DEPTH];

  logic        cfg_prop, cfg_narrow, cfg_pal_en;
  logic [2:0]  cfg_xs, cfg_ys;

  // placements still owed by the block, oldest first
  pgp_pkg::res_t expected_glyphs [$];

  idle_mode_t  idle_mode;
  int          mismatches, items_sent, glyphs_checked, markers_checked;
  int          kern_hits, escapes_taken, settings_used, quiet_cycles;

  // characters with shifts or kerning, mixed into random strings
  string glyph_mix = "Taeiouyrwvlft LFA671.,:;'!m_$%&*IJVYbcdghjknpqsxz";

  // ---------------------------------------------------------------------------
  // placement model: one input beat in, at most one expected result out
  // ---------------------------------------------------------------------------
  function automatic logic place_glyph(input pgp_pkg::item_t it,
                                       output pgp_pkg::res_t want);
    logic [7:0] c;
    logic       kern;
    int         lft, rgt, xs, ys, vs, x, cy, nx, digit;
    c    = it.char_code;
    want = '0;

    // palette write: no result, string context untouched
    if (it.req_type == REQ_PALETTE) begin
      palette_mem[it.palette_slot] = it.palette_color;
      return 1'b0;
    end

    // string start loads pen, colours and fill settings
    if (it.first_char) begin
      pen_x       = it.start_x;
      pen_y       = it.start_y;
      base_color  = it.text_color;
      cur_color   = it.text_color;
      fill_on     = it.fill_enable;
      back_color  = it.fill_color;
      esc_pending = 1'b0;
    end

    // byte after a colour escape is consumed
    if (esc_pending) begin
      esc_pending = 1'b0;
      escapes_taken++;
      digit = int'(c) - int'(pgp_pkg::CH_ONE);
      if (cfg_pal_en) begin
        if (c == pgp_pkg::CH_ZERO) begin
          cur_color = base_color;
        end else if (digit >= 0 && digit < pgp_pkg::PALETTE_DEPTH) begin
          cur_color = palette_mem[digit];
        end
      end
      prev_byte = c;
      if (!it.last_char) return 1'b0;
      // string ends on the escape: end marker only
      want.next_x        = pen_x;
      want.end_of_string = 1'b1;
      return 1'b1;
    end

    // backspace not at the end opens an escape
    if (c == pgp_pkg::CH_BS && !it.last_char) begin
      esc_pending = 1'b1;
      prev_byte   = c;
      return 1'b0;
    end

    xs  = cfg_xs;
    ys  = cfg_ys;
    lft = 0;
    rgt = 0;
    if (cfg_prop) begin
      case (c)
        pgp_pkg::CH_SPACE:   rgt = cfg_narrow ? -5 : 0;
        ".", ",", ":", ";": begin lft = -2; rgt = -2; end
        "'":                begin lft = -3; rgt = -1; end
        "!":                begin lft = -3; rgt = -2; end
        "$", "%", "&", "*", "T", "V", "Y": rgt = 1;
        "f", "t":           begin lft = -1; rgt = -1; end
        "i", "l":           lft = -2;
        "m", "w":           begin lft = -1; rgt = 1; end
        "1", "a", "b", "c", "d", "e", "g", "h", "j", "k", "n", "o", "p",
        "q", "r", "s", "u", "v", "x", "y", "z", "I", "J", "_", 8'hBA:
                            lft = -1;
        default: ;
      endcase
      lft = lft * xs;
      rgt = rgt * xs;
    end

    // control glyphs sit lower on the line
    case (c)
      8'h0E:                      vs = 1;
      8'h10, 8'h11, 8'h1E, 8'h1F: vs = 2;
      8'h1A, 8'h1B:               vs = 3;
      default:                    vs = 0;
    endcase

    kern = 1'b0;
    if (!it.first_char && cfg_prop) begin
      case ({prev_byte, c})
        "vi", "it", "if", "lt", "lf", "lv", "lT", "ri", "rl", "LT", "Ta", "Te",
        "Ti", "To", "Tu", "Ty", "Tr", "Tw", "Fi", "Fl", "FA", "67", "17":
          kern = 1'b1;
        default: ;
      endcase
    end
    if (kern) kern_hits++;

    x = $signed(pen_x) + lft;
    if (kern) x = x - xs;
    cy = $signed(pen_y) + (vs * ys) / 2;
    nx = x + pgp_pkg::GLYPH_WIDTH * xs + rgt;

    want.glyph_valid   = 1'b1;
    want.glyph         = c;
    want.cursor_x      = 16'(x);
    want.cursor_y      = 16'(cy);
    want.glyph_color   = cur_color;
    want.fill_valid    = fill_on;
    if (fill_on) begin
      want.fill_x      = pen_x;
      want.fill_width  = 6'(pgp_pkg::GLYPH_WIDTH * xs + lft + rgt);
      want.fill_height = 7'(pgp_pkg::GLYPH_HEIGHT * ys);
    end
    want.next_x        = 16'(nx);
    want.end_of_string = it.last_char;

    pen_x     = 16'(nx);
    prev_byte = c;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int idle_draw();
    case (idle_mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? 1 : 0;
      default:    return $urandom_range(0, 7);
    endcase
  endfunction

  // string byte with the unused fields scrambled
  function automatic pgp_pkg::item_t byte_item(input logic [7:0] c, input logic is_first,
                                               input logic is_last);
    pgp_pkg::item_t it;
    it.req_type      = REQ_BYTE;
    it.char_code     = c;
    it.first_char    = is_first;
    it.last_char     = is_last;
    it.start_x       = 16'($urandom);
    it.start_y       = 16'($urandom);
    it.text_color    = 16'($urandom);
    it.fill_enable   = 1'($urandom_range(0, 1));
    it.fill_color    = 16'($urandom);
    it.palette_slot  = 3'($urandom_range(0, 7));
    it.palette_color = 16'($urandom);
    return it;
  endfunction

  function automatic pgp_pkg::item_t palette_item(input logic [2:0] slot,
                                                  input logic [15:0] colour);
    pgp_pkg::item_t it;
    it               = byte_item(8'($urandom), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
    it.req_type      = REQ_PALETTE;
    it.palette_slot  = slot;
    it.palette_color = colour;
    return it;
  endfunction

  // mostly interesting glyphs; after a backspace mostly a digit
  function automatic logic [7:0] pick_char(input logic after_escape);
    int sel;
    if (after_escape && $urandom_range(0, 4) != 0)
      return 8'(pgp_pkg::CH_ZERO + $urandom_range(0, 9));
    sel = $urandom_range(0, 15);
    if (sel < 8)  return 8'(glyph_mix[$urandom_range(0, glyph_mix.len() - 1)]);
    if (sel < 10) return pgp_pkg::CH_BS;
    if (sel == 10) begin
      case ($urandom_range(0, 7))
        0:       return 8'h0E;
        1:       return 8'h10;
        2:       return 8'h11;
        3:       return 8'h1A;
        4:       return 8'h1B;
        5:       return 8'h1E;
        6:       return 8'h1F;
        default: return 8'hBA;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // one input beat: optional gap, then hold valid until taken
  task automatic send_beat(input pgp_pkg::item_t it);
    int            gap;
    pgp_pkg::res_t want;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type      = it.req_type;
    in_char_code     = it.char_code;
    in_first_char    = it.first_char;
    in_last_char     = it.last_char;
    in_start_x       = it.start_x;
    in_start_y       = it.start_y;
    in_text_color    = it.text_color;
    in_fill_enable   = it.fill_enable;
    in_fill_color    = it.fill_color;
    in_palette_slot  = it.palette_slot;
    in_palette_color = it.palette_color;
    in_valid         = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (place_glyph(it, want)) expected_glyphs.push_back(want);
    items_sent++;
    @(negedge clk);
  endtask

  // block idle: nothing owed and any palette write has passed through
  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input pgp_pkg::cfg_idx_t idx, input logic [7:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pgp_pkg::CFG_PROPORTIONAL:   cfg_prop   = val[0];
      pgp_pkg::CFG_SPACE_NARROW:   cfg_narrow = val[0];
      pgp_pkg::CFG_X_SCALE:        cfg_xs     = val[2:0];
      pgp_pkg::CFG_Y_SCALE:        cfg_ys     = val[2:0];
      pgp_pkg::CFG_PALETTE_ENABLE: cfg_pal_en = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic prop, input logic narrow, input logic [2:0] xs,
                               input logic [2:0] ys, input logic pal_en);
    wait_drained();
    write_reg(pgp_pkg::CFG_PROPORTIONAL,   {7'd0, prop});
    write_reg(pgp_pkg::CFG_SPACE_NARROW,   {7'd0, narrow});
    write_reg(pgp_pkg::CFG_X_SCALE,        {5'd0, xs});
    write_reg(pgp_pkg::CFG_Y_SCALE,        {5'd0, ys});
    write_reg(pgp_pkg::CFG_PALETTE_ENABLE, {7'd0, pal_en});
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // fill every palette slot first so no escape reads an empty entry
  task automatic test_palette_load();
    for (int s = 0; s < pgp_pkg::PALETTE_DEPTH; s++) begin
      if (s == 0)
        send_beat(palette_item(3'(s), 16'h0000));
      else if (s == pgp_pkg::PALETTE_DEPTH - 1)
        send_beat(palette_item(3'(s), 16'hFFFF));
      else
        send_beat(palette_item(3'(s), 16'($urandom)));
    end
  endtask

  // pen and baseline wrap, kerning, shifts, fill on and off
  task automatic test_placement_extremes();
    pgp_pkg::item_t it;
    it             = byte_item("T", 1'b1, 1'b0);
    it.start_x     = 16'h7FFF;
    it.start_y     = 16'h8000;
    it.text_color  = 16'hFFFF;
    it.fill_enable = 1'b1;
    it.fill_color  = 16'h0000;
    send_beat(it);
    send_beat(byte_item("a", 1'b0, 1'b0));
    send_beat(byte_item(pgp_pkg::CH_SPACE, 1'b0, 1'b0));
    send_beat(byte_item(8'h1A, 1'b0, 1'b0));
    send_beat(byte_item("T", 1'b0, 1'b1));
    // new string: no kerning across the string boundary
    it             = byte_item("a", 1'b1, 1'b0);
    it.start_x     = 16'h8000;
    it.start_y     = 16'h7FFF;
    it.text_color  = 16'h0000;
    it.fill_enable = 1'b0;
    it.fill_color  = 16'hFFFF;
    send_beat(it);
    send_beat(byte_item("'", 1'b0, 1'b0));
    send_beat(byte_item(8'h1B, 1'b0, 1'b0));
    send_beat(byte_item(8'hFF, 1'b0, 1'b1));
    // a lone backspace at the end is drawn
    send_beat(byte_item(pgp_pkg::CH_BS, 1'b1, 1'b1));
  endtask

  // base colour, first and last palette slot, digit past the palette,
  // string ending on the escape
  task automatic test_colour_escapes();
    apply_setting(1'b1, 1'b1, 3'd1, 3'd1, 1'b1);
    send_beat(byte_item(pgp_pkg::CH_BS, 1'b1, 1'b0));
    send_beat(byte_item(pgp_pkg::CH_ONE, 1'b0, 1'b0));
    send_beat(byte_item("A", 1'b0, 1'b0));
    send_beat(byte_item(pgp_pkg::CH_BS, 1'b0, 1'b0));
    send_beat(byte_item(8'(pgp_pkg::CH_ONE + pgp_pkg::PALETTE_DEPTH - 1), 1'b0, 1'b0));
    send_beat(byte_item("B", 1'b0, 1'b0));
    send_beat(byte_item(pgp_pkg::CH_BS, 1'b0, 1'b0));
    send_beat(byte_item(8'(pgp_pkg::CH_ONE + pgp_pkg::PALETTE_DEPTH), 1'b0, 1'b0));
    send_beat(byte_item(pgp_pkg::CH_BS, 1'b0, 1'b0));
    send_beat(byte_item(pgp_pkg::CH_ZERO, 1'b0, 1'b0));
    send_beat(byte_item(pgp_pkg::CH_BS, 1'b0, 1'b0));
    send_beat(byte_item(8'(pgp_pkg::CH_ONE + 1), 1'b0, 1'b1));
  endtask

  // mostly whole strings, some palette writes and loose bytes as noise
  task automatic test_random_strings(input int n_items);
    int             target, len;
    logic           after_escape;
    logic [7:0]     c;
    pgp_pkg::item_t it;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 7) == 0) idle_mode = idle_mode_t'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0: send_beat(palette_item(3'($urandom_range(0, 7)), 16'($urandom)));
        1: send_beat(byte_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1))));
        default: begin
          len          = $urandom_range(1, 12);
          after_escape = 1'b0;
          for (int k = 0; k < len; k++) begin
            c  = pick_char(after_escape);
            it = byte_item(c, k == 0, k == len - 1);
            // some strings start close to the wrap point
            if (k == 0 && $urandom_range(0, 3) == 0)
              it.start_x = 16'h7F00 + 16'($urandom_range(0, 255));
            after_escape = (c == pgp_pkg::CH_BS) && !after_escape;
            send_beat(it);
          end
        end
      endcase
    end
  endtask

  // every register moved, scales between 1 and 4
  task automatic test_config_sweep();
    apply_setting(1'b1, 1'b1, 3'd1, 3'd1, 1'b0);
    test_random_strings(150);
    apply_setting(1'b0, 1'b0, 3'd4, 3'd4, 1'b1);
    test_random_strings(150);
    apply_setting(1'b1, 1'b0, 3'd4, 3'd4, 1'b1);
    test_random_strings(150);
    apply_setting(1'b1, 1'b1, 3'd4, 3'd1, 1'b0);
    test_random_strings(150);
    apply_setting(1'b0, 1'b1, 3'd1, 3'd4, 1'b1);
    test_random_strings(150);
    apply_setting(1'b1, 1'b1, 3'd2, 3'd3, 1'b1);
    test_random_strings(150);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch %0d at %0t: %s", mismatches, $time, what);
  endtask

  task automatic check_field(input string field, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", field, got, want));
  endtask

  always @(posedge clk) begin : result_check
    pgp_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_glyphs.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing owed, glyph %h", out_glyph));
      end else begin
        want = expected_glyphs.pop_front();
        check_field("glyph_valid",   out_glyph_valid,   want.glyph_valid);
        check_field("glyph",         out_glyph,         want.glyph);
        check_field("cursor_x",      out_cursor_x,      want.cursor_x);
        check_field("cursor_y",      out_cursor_y,      want.cursor_y);
        check_field("glyph_color",   out_glyph_color,   want.glyph_color);
        check_field("fill_valid",    out_fill_valid,    want.fill_valid);
        check_field("fill_x",        out_fill_x,        want.fill_x);
        check_field("fill_width",    out_fill_width,    want.fill_width);
        check_field("fill_height",   out_fill_height,   want.fill_height);
        check_field("next_x",        out_next_x,        want.next_x);
        check_field("end_of_string", out_end_of_string, want.end_of_string);
        if (want.glyph_valid) glyphs_checked++;
        else markers_checked++;
      end
    end
  end

  // no beat on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_glyphs.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // clock, result sink and main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall before each result beat
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = pgp_pkg::CFG_PROPORTIONAL;
    cfg_data         = 8'd0;
    in_valid         = 1'b0;
    in_req_type      = REQ_BYTE;
    in_char_code     = 8'd0;
    in_first_char    = 1'b0;
    in_last_char     = 1'b0;
    in_start_x       = 16'd0;
    in_start_y       = 16'd0;
    in_text_color    = 16'd0;
    in_fill_enable   = 1'b0;
    in_fill_color    = 16'd0;
    in_palette_slot  = 3'd0;
    in_palette_color = 16'd0;
    idle_mode        = IDLE_RANDOM;
    mismatches       = 0;
    items_sent       = 0;
    glyphs_checked   = 0;
    markers_checked  = 0;
    kern_hits        = 0;
    escapes_taken    = 0;
    settings_used    = 0;
    quiet_cycles     = 0;

    // model state after reset
    pen_x       = '0;
    pen_y       = '0;
    cur_color   = '0;
    base_color  = '0;
    back_color  = '0;
    fill_on     = 1'b0;
    prev_byte   = '0;
    esc_pending = 1'b0;
    cfg_prop    = 1'b1;
    cfg_narrow  = 1'b1;
    cfg_xs      = 3'd1;
    cfg_ys      = 3'd1;
    cfg_pal_en  = 1'b0;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_palette_load();
    test_placement_extremes();
    test_colour_escapes();
    test_config_sweep();

    // drain, then let the pipeline run dry
    in_valid = 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d input beats under %0d register settings",
             items_sent, settings_used);
    $display("checked %0d glyphs, %0d end markers, %0d kerned pairs, %0d colour escapes",
             glyphs_checked, markers_checked, kern_hits, escapes_taken);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
